[rtl/core/pattern_deletion_stream_filter_defines.svh]
// ----------------------------------------------------------------------------
// pattern deletion stream filter assertion macros
// shared property wrappers for the filter's concurrent checks
// ----------------------------------------------------------------------------
`ifndef PATTERN_DELETION_STREAM_FILTER_DEFINES_SVH
`define PATTERN_DELETION_STREAM_FILTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PDSF_ASSERT_ALWAYS(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdsf assertion failed");

// next-cycle implication, checked outside reset
`define PDSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdsf assertion failed");

`endif

[rtl/core/pdsf_pkg.sv]
// ----------------------------------------------------------------------------
// pdsf_pkg
// shared widths, register indexes and types of the pattern deletion filter
// ----------------------------------------------------------------------------
`default_nettype none

package pdsf_pkg;

	// element and configuration widths
	localparam int ELEM_W    = 16;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 8;
	localparam int LEN_W     = 4;

	// pattern elements held in the two pattern registers
	localparam int PAT_PER_REG = CFG_W / ELEM_W;
	localparam int PAT_REG_MAX = 2 * PAT_PER_REG;

	// default window depth
	localparam int MAX_PATTERN_DEF = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 8'd2;

	// one result word
	typedef struct packed {
		logic [ELEM_W-1:0] kept_element;
		logic              has_value;
		logic              stream_end;
	} out_word_t;

	// control broadcast to every window cell
	typedef struct packed {
		logic take;
		logic shift;
	} cell_ctl_t;

	// pattern element k out of the two pattern registers, zero beyond them
	function automatic logic [ELEM_W-1:0] pat_elem(input int k,
			input logic [CFG_W-1:0] low, input logic [CFG_W-1:0] high);
		logic [ELEM_W-1:0] v;
		v = '0;
		if (k < PAT_PER_REG) begin
			v = low[ELEM_W*k +: ELEM_W];
		end else if (k < PAT_REG_MAX) begin
			v = high[ELEM_W*(k-PAT_PER_REG) +: ELEM_W];
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/core/pdsf_in_if.sv]
// ----------------------------------------------------------------------------
// pdsf_in_if
// input channel of the filter: one element word per handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface pdsf_in_if;
	logic                      valid;
	logic                      ready;
	logic [pdsf_pkg::ELEM_W-1:0] element;
	logic                      is_last;

	modport source (output valid, output element, output is_last, input ready);
	modport sink   (input valid, input element, input is_last, output ready);
endinterface

`default_nettype wire

[rtl/core/pdsf_out_if.sv]
// ----------------------------------------------------------------------------
// pdsf_out_if
// output channel of the filter: one kept element or end marker per word
// ----------------------------------------------------------------------------
`default_nettype none

interface pdsf_out_if;
	logic                      valid;
	logic                      ready;
	logic [pdsf_pkg::ELEM_W-1:0] kept_element;
	logic                      has_value;
	logic                      stream_end;

	modport source (output valid, output kept_element, output has_value,
		output stream_end, input ready);
	modport sink   (input valid, input kept_element, input has_value,
		input stream_end, output ready);
endinterface

`default_nettype wire

[rtl/core/pattern_deletion_stream_filter.sv]
// ----------------------------------------------------------------------------
// pattern_deletion_stream_filter
// removes every non-overlapping occurrence of a configured pattern from an
// element stream, matching greedily from left to right
// ----------------------------------------------------------------------------
// Elements pass through a chain of MAX_PATTERN window cells that is compared
// against the pattern in parallel; the window does one action per cycle
// (append plus one drop-or-emit) and the output buffer takes one word per
// cycle, so in steady flow, while the buffer has room, one element is taken
// every cycle. An element marked last drains the window one action at a
// time; a closing action then tags the final word with stream_end, or sends
// a bare end marker when nothing is left. After the pattern length has been
// lowered, the next element also drains the surplus held elements before new
// input is taken. Configuration writes take effect on the next cycle; there
// is no clearing pass after reset.
`default_nettype none

`include "pattern_deletion_stream_filter_defines.svh"

module pattern_deletion_stream_filter #(
	parameter int MAX_PATTERN = pdsf_pkg::MAX_PATTERN_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [pdsf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pdsf_pkg::CFG_W-1:0]     cfg_data,
	pdsf_in_if.sink                             items,
	pdsf_out_if.source                          results
);

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int EW     = pdsf_pkg::ELEM_W;

	// configuration registers
	logic [pdsf_pkg::LEN_W-1:0] pattern_len_q;
	logic [pdsf_pkg::CFG_W-1:0] pattern_low_q;
	logic [pdsf_pkg::CFG_W-1:0] pattern_high_q;

	// window control state
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] skip_q;
	logic              act_q;
	logic              last_q;
	logic              pv_q;
	logic [EW-1:0]     pend_q;

	// datapath
	logic [FILL_W-1:0]   len;
	logic                take;
	logic                go;
	logic                full;
	logic                fifo_full_w;
	logic [FILL_W-1:0]   cur_fill;
	logic                cur_last;
	logic                need_scan;
	logic                flush_one;
	logic                match;
	logic [EW-1:0]       cur_w [MAX_PATTERN];
	logic [EW-1:0]       nbr_w [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq_v;
	pdsf_pkg::cell_ctl_t ctl;

	logic                shift;
	logic                emit;
	logic                close;
	logic                more;
	logic [FILL_W-1:0]   fill_n;
	logic [FILL_W-1:0]   skip_n;
	logic                act_n;
	logic                push;
	pdsf_pkg::out_word_t push_word;

	// configuration writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q  <= pdsf_pkg::LEN_W'(1);
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pdsf_pkg::REG_PATTERN_LEN:  pattern_len_q  <= cfg_data[pdsf_pkg::LEN_W-1:0];
				pdsf_pkg::REG_PATTERN_LOW:  pattern_low_q  <= cfg_data;
				pdsf_pkg::REG_PATTERN_HIGH: pattern_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pattern length saturated to the window depth
	always_comb begin
		if (int'(pattern_len_q) > MAX_PATTERN) begin
			len = FILL_W'(MAX_PATTERN);
		end else begin
			len = FILL_W'(pattern_len_q);
		end
	end

	// input handshake: one step at a time, buffer room for one push
	assign full        = fifo_full_w;
	assign items.ready = !act_q && !full;
	assign take        = items.valid && items.ready;
	assign go          = (take || act_q) && !full;

	// window as seen this cycle with the new word appended
	assign cur_fill  = fill_q + FILL_W'(take);
	assign cur_last  = take ? items.is_last : last_q;
	assign need_scan = (len != '0) && (cur_fill >= len);
	assign flush_one = ((len == '0) || cur_last) && (cur_fill != '0);
	assign match     = &eq_v;

	assign ctl.take  = take;
	assign ctl.shift = shift;

	// chain of window cells
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		if (i == MAX_PATTERN - 1) begin : g_top
			assign nbr_w[i] = '0;
		end else begin : g_mid
			assign nbr_w[i] = cur_w[i+1];
		end

		pdsf_cell #(
			.FILL_W (FILL_W),
			.INDEX  (i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.fill    (fill_q),
			.len     (len),
			.element (items.element),
			.pat     (pdsf_pkg::pat_elem(i, pattern_low_q, pattern_high_q)),
			.nbr     (nbr_w[i]),
			.cur     (cur_w[i]),
			.eq      (eq_v[i])
		);
	end

	// one window action per cycle while the output buffer has room
	always_comb begin
		shift  = 1'b0;
		emit   = 1'b0;
		close  = 1'b0;
		fill_n = cur_fill;
		skip_n = skip_q;
		if (go) begin
			if (skip_q != '0) begin
				// finish dropping a matched run that left elements behind it
				shift  = 1'b1;
				fill_n = cur_fill - FILL_W'(1);
				skip_n = skip_q - FILL_W'(1);
			end else if (need_scan) begin
				if (match) begin
					if (cur_fill == len) begin
						fill_n = '0;
					end else begin
						shift  = 1'b1;
						fill_n = cur_fill - FILL_W'(1);
						skip_n = len - FILL_W'(1);
					end
				end else begin
					emit   = 1'b1;
					shift  = 1'b1;
					fill_n = cur_fill - FILL_W'(1);
				end
			end else if (flush_one) begin
				emit   = 1'b1;
				shift  = 1'b1;
				fill_n = cur_fill - FILL_W'(1);
			end else begin
				close = cur_last;
			end
		end
	end

	// work left in the window after this action
	assign more = (skip_n != '0) || ((len != '0) && (fill_n >= len))
		|| (((len == '0) || cur_last) && (fill_n != '0));

	always_comb begin
		act_n = act_q;
		if (go) begin
			act_n = cur_last ? !close : more;
		end
	end

	// result words; in a last step each word waits one action so the final
	// one can carry stream_end
	always_comb begin
		push      = go && ((emit && (!cur_last || pv_q)) || close);
		push_word = '{kept_element: cur_w[0], has_value: 1'b1, stream_end: 1'b0};
		if (close) begin
			push_word = '{kept_element: pv_q ? pend_q : '0, has_value: pv_q,
				stream_end: 1'b1};
		end else if (cur_last) begin
			push_word = '{kept_element: pend_q, has_value: 1'b1, stream_end: 1'b0};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			skip_q <= '0;
			act_q  <= 1'b0;
			last_q <= 1'b0;
			pv_q   <= 1'b0;
		end else begin
			if (go) begin
				fill_q <= fill_n;
				skip_q <= skip_n;
			end
			act_q <= act_n;
			if (take) begin
				last_q <= items.is_last;
			end
			if (go && emit && cur_last) begin
				pv_q <= 1'b1;
			end else if (close) begin
				pv_q <= 1'b0;
			end
		end
	end

	// word held back during a last step
	always_ff @(posedge clk) begin
		if (go && emit && cur_last) begin
			pend_q <= cur_w[0];
		end
	end

	// output buffer
	pdsf_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.full      (fifo_full_w),
		.results   (results)
	);

	// checks
	`PDSF_ASSERT_ALWAYS(a_skip_in_step, clk, arst_n, skip_q != '0, act_q)
	`PDSF_ASSERT_ALWAYS(a_pend_in_last, clk, arst_n, pv_q, act_q && last_q)
	`PDSF_ASSERT_ALWAYS(a_no_overflow, clk, arst_n, push, !fifo_full_w)
	`PDSF_ASSERT_NEXT(a_close_ends_step, clk, arst_n, close, !act_q && !pv_q)

endmodule

`default_nettype wire

[rtl/core/pdsf_cell.sv]
// ----------------------------------------------------------------------------
// pdsf_cell
// one window slot: holds an element, takes the incoming word at the fill
// position, shifts from its upper neighbour and compares against its pattern
// ----------------------------------------------------------------------------
`default_nettype none

module pdsf_cell #(
	parameter int FILL_W = 4,
	parameter int INDEX  = 0
) (
	input  wire logic                          clk,
	input  wire pdsf_pkg::cell_ctl_t           ctl,
	input  wire logic [FILL_W-1:0]             fill,
	input  wire logic [FILL_W-1:0]             len,
	input  wire logic [pdsf_pkg::ELEM_W-1:0]   element,
	input  wire logic [pdsf_pkg::ELEM_W-1:0]   pat,
	input  wire logic [pdsf_pkg::ELEM_W-1:0]   nbr,
	output logic      [pdsf_pkg::ELEM_W-1:0]   cur,
	output logic                               eq
);

	logic [pdsf_pkg::ELEM_W-1:0] slot_q;
	logic                        load;

	// slot content with the incoming word appended at the fill position
	assign load = ctl.take && (fill == FILL_W'(INDEX));
	assign cur  = load ? element : slot_q;

	// slots at or beyond the pattern length do not take part in the match
	assign eq = (cur == pat) || (FILL_W'(INDEX) >= len);

	// hold or shift down by one
	always_ff @(posedge clk) begin
		slot_q <= ctl.shift ? nbr : cur;
	end

endmodule

`default_nettype wire

[rtl/core/pdsf_out_fifo.sv]
// ----------------------------------------------------------------------------
// pdsf_out_fifo
// two-word output buffer that parts the window from the downstream handshake
// ----------------------------------------------------------------------------
`default_nettype none

module pdsf_out_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire pdsf_pkg::out_word_t   push_word,
	output logic                       full,
	pdsf_out_if.source                 results
);

	pdsf_pkg::out_word_t slot_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          count_q;
	logic                pop;
	pdsf_pkg::out_word_t head;

	assign pop  = results.valid && results.ready;
	assign full = (count_q == 2'd2);
	assign head = slot_q[rd_ptr_q];

	// head word to the port
	assign results.valid        = (count_q != 2'd0);
	assign results.kept_element = head.kept_element;
	assign results.has_value    = head.has_value;
	assign results.stream_end   = head.stream_end;

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

`default_nettype wire
